@@ rtl/core/cfv_pkg.sv @@
// Shared types, codes and helpers for the checked frame validator.
package cfv_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam logic [WORD_W-1:0] MIN_FRAME = 16'd8;
    localparam logic [WORD_W-1:0] TAIL_BACK = 16'd4;
    localparam logic [WORD_W-1:0] SUM_BACK  = 16'd2;

    localparam logic [WORD_W-1:0] RST_HEAD_MARKER = 16'd0;
    localparam logic [WORD_W-1:0] RST_TAIL_MARKER = 16'd0;
    localparam logic [WORD_W-1:0] RST_MAX_PAYLOAD = 16'd1024;
    localparam logic              RST_BIG_ENDIAN  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_MARKER = 8'd0,
        CFG_TAIL_MARKER = 8'd1,
        CFG_MAX_PAYLOAD = 8'd2,
        CFG_BIG_ENDIAN  = 8'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_SUM  = 2'd3
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] head_marker;
        logic [WORD_W-1:0] tail_marker;
        logic [WORD_W-1:0] max_payload;
        logic              big_endian;
    } t_cfg;

    typedef struct packed {
        logic              emit;
        t_status           status;
        logic [WORD_W-1:0] frame_size;
    } t_result;

    function automatic logic [WORD_W-1:0] join_word(
        input logic [BYTE_W-1:0] first,
        input logic [BYTE_W-1:0] second,
        input logic              big_endian
    );
        logic [WORD_W-1:0] w;
        w = big_endian ? {first, second} : {second, first};
        return w;
    endfunction

endpackage

@@ rtl/core/checked_frame_validator_core.sv @@
// Top level of the checked frame validator: input stage, parser, result register.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+-------------------------------
//  in      | i_in_valid  | o_in_ready   | i_data_byte, i_frame_start
//  out     | o_out_valid | i_out_ready  | o_status, o_frame_size
//  cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One byte per cycle while no result stalls; each status is registered.
//  Input register -> parser logic -> result register; the parser state update
//  and the result write happen in the same cycle.
//  Reset is synchronous, active low; cfg registers return to their defaults.
//  A stalled result blocks the input register, which then holds one more byte.
module checked_frame_validator_core
    import cfv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_frame_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [WORD_W-1:0]    o_frame_size,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_size;

    t_cfg    cfg;
    t_result result;
    logic    out_free;
    logic    step;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    cfv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    cfv_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_data_byte   (r_in_byte),
        .i_frame_start (r_in_start),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= result.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.emit) begin
            r_out_status <= result.status;
            r_out_size   <= result.frame_size;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_frame_size = r_out_size;

`ifndef SYNTHESIS
    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("empty input stage not ready");
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_size))
        else $error("pending result lost");
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && result.emit |=> r_out_valid)
        else $error("status not registered");
`endif

endmodule

@@ rtl/core/cfv_cfg.sv @@
// Configuration register bank for the checked frame validator.
module cfv_cfg
    import cfv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAD_MARKER: n_cfg.head_marker = i_cfg_data;
                CFG_TAIL_MARKER: n_cfg.tail_marker = i_cfg_data;
                CFG_MAX_PAYLOAD: n_cfg.max_payload = i_cfg_data;
                CFG_BIG_ENDIAN:  n_cfg.big_endian  = i_cfg_data[0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_marker <= RST_HEAD_MARKER;
            r_cfg.tail_marker <= RST_TAIL_MARKER;
            r_cfg.max_payload <= RST_MAX_PAYLOAD;
            r_cfg.big_endian  <= RST_BIG_ENDIAN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/core/cfv_parser.sv @@
// Per-byte frame state and status decision for the checked frame validator.
module cfv_parser
    import cfv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_frame_start,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic [WORD_W-1:0] r_pos, n_pos;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic [WORD_W-1:0] r_size, n_size;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_tail_ok, n_tail_ok;
    logic              r_in_frame, n_in_frame;

    logic [WORD_W-1:0] c_pos, c_sum, c_size;
    logic [BYTE_W-1:0] c_held;
    logic              c_tail_ok, c_in_frame;
    logic [WORD_W-1:0] word;
    logic [WORD_W:0]   size_limit;
    t_result           res;

    always_comb begin
        c_pos      = i_frame_start ? '0 : r_pos;
        c_sum      = i_frame_start ? '0 : r_sum;
        c_size     = i_frame_start ? '0 : r_size;
        c_held     = i_frame_start ? '0 : r_held;
        c_tail_ok  = i_frame_start ? 1'b0 : r_tail_ok;
        c_in_frame = i_frame_start | r_in_frame;

        word       = join_word(c_held, i_data_byte, i_cfg.big_endian);
        size_limit = {1'b0, i_cfg.max_payload} + {1'b0, MIN_FRAME};

        n_pos      = c_pos;
        n_sum      = c_sum;
        n_size     = c_size;
        n_held     = c_held;
        n_tail_ok  = c_tail_ok;
        n_in_frame = c_in_frame;
        res        = '{emit: 1'b0, status: ST_OK, frame_size: '0};

        if (c_in_frame) begin
            n_pos = c_pos + 16'd1;
            if (c_pos < 16'd4) begin
                n_sum = c_sum + {8'd0, i_data_byte};
                if (c_pos[0] == 1'b0) begin
                    n_held = i_data_byte;
                end else if (c_pos[1] == 1'b0) begin
                    if (word != i_cfg.head_marker) begin
                        res = '{emit: 1'b1, status: ST_BAD_CODE, frame_size: '0};
                    end
                end else begin
                    if (word < MIN_FRAME || {1'b0, word} > size_limit) begin
                        res = '{emit: 1'b1, status: ST_BAD_SIZE, frame_size: word};
                    end else begin
                        n_size = word;
                    end
                end
            end else begin
                if (c_pos < c_size - SUM_BACK) begin
                    n_sum = c_sum + {8'd0, i_data_byte};
                end
                if (c_pos == c_size - TAIL_BACK || c_pos == c_size - SUM_BACK) begin
                    n_held = i_data_byte;
                end else if (c_pos == c_size - TAIL_BACK + 16'd1) begin
                    n_tail_ok = (word == i_cfg.tail_marker);
                end else if (c_pos == c_size - 16'd1) begin
                    priority if (!c_tail_ok) begin
                        res = '{emit: 1'b1, status: ST_BAD_CODE, frame_size: c_size};
                    end else if (word != c_sum) begin
                        res = '{emit: 1'b1, status: ST_BAD_SUM, frame_size: c_size};
                    end else begin
                        res = '{emit: 1'b1, status: ST_OK, frame_size: c_size};
                    end
                end
            end
            if (res.emit) begin
                n_in_frame = 1'b0;
            end
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_size     <= '0;
            r_held     <= '0;
            r_tail_ok  <= 1'b0;
            r_in_frame <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_size     <= n_size;
            r_held     <= n_held;
            r_tail_ok  <= n_tail_ok;
            r_in_frame <= n_in_frame;
        end
    end

`ifndef SYNTHESIS
    a_emit_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.emit |=> !r_in_frame)
        else $error("frame still open after status");
    a_size_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame && r_pos >= 16'd4 |-> r_size >= MIN_FRAME)
        else $error("payload phase with unchecked size");
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame && r_pos >= 16'd4 |-> r_pos < r_size)
        else $error("byte position past frame end");
`endif

endmodule

@@ dv/tb_checked_frame_validator_core.sv @@
// Testbench for checked_frame_validator_core: randomized framed byte traffic checked per status.
module tb_checked_frame_validator_core
    import cfv_pkg::*;
();

    typedef struct {
        t_status           status;
        logic [WORD_W-1:0] size;
    } t_due_status;

    typedef enum {
        FK_GOOD,
        FK_BAD_HEAD,
        FK_SIZE_LOW,
        FK_SIZE_HIGH,
        FK_BAD_TAIL,
        FK_BAD_SUM,
        FK_CUT,
        FK_NOISE
    } t_frame_kind;

    class frame_status_tracker;
        logic [WORD_W-1:0] head_key;
        logic [WORD_W-1:0] tail_key;
        logic [WORD_W-1:0] payload_limit;
        logic              msb_first;

        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] run_sum;
        logic [WORD_W-1:0] size_word;
        logic [BYTE_W-1:0] first_byte;
        logic              tail_match;
        logic              busy;

        t_due_status       due_statuses[$];
        int unsigned       errors;
        int unsigned       posted;
        int unsigned       status_hits[4];

        function new();
            head_key      = RST_HEAD_MARKER;
            tail_key      = RST_TAIL_MARKER;
            payload_limit = RST_MAX_PAYLOAD;
            msb_first     = RST_BIG_ENDIAN;
            pos           = '0;
            run_sum       = '0;
            size_word     = '0;
            first_byte    = '0;
            tail_match    = 1'b0;
            busy          = 1'b0;
            errors        = 0;
            posted        = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function logic [WORD_W-1:0] pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
            return msb_first ? {a, b} : {b, a};
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
            unique case (idx)
                CFG_HEAD_MARKER: head_key = data;
                CFG_TAIL_MARKER: tail_key = data;
                CFG_MAX_PAYLOAD: payload_limit = data;
                CFG_BIG_ENDIAN:  msb_first = data[0];
                default: ;
            endcase
        endfunction

        function void post(input t_status st, input logic [WORD_W-1:0] sz);
            t_due_status d;
            d.status = st;
            d.size   = sz;
            due_statuses.push_back(d);
            posted++;
            busy = 1'b0;
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b, input logic start);
            int unsigned p;
            int unsigned lim;
            int unsigned wi;
            logic [WORD_W-1:0] w;
            if (start) begin
                pos        = '0;
                run_sum    = '0;
                size_word  = '0;
                first_byte = '0;
                tail_match = 1'b0;
                busy       = 1'b1;
            end
            if (!busy) return;
            p   = 32'(pos);
            pos = pos + 1'b1;
            if (p < 4) begin
                run_sum = run_sum + b;
                if (p == 0 || p == 2) begin
                    first_byte = b;
                    return;
                end
                w = pair(first_byte, b);
                if (p == 1) begin
                    if (w != head_key) post(ST_BAD_CODE, '0);
                    return;
                end
                wi = 32'(w);
                if (wi < 32'(MIN_FRAME) || wi > 32'(payload_limit) + 32'(MIN_FRAME))
                    post(ST_BAD_SIZE, w);
                else size_word = w;
                return;
            end
            lim = 32'(size_word);
            if (p < lim - 32'(SUM_BACK)) run_sum = run_sum + b;
            if (p == lim - 32'(TAIL_BACK) || p == lim - 32'(SUM_BACK)) begin
                first_byte = b;
                return;
            end
            if (p == lim - 32'(TAIL_BACK) + 1) begin
                tail_match = (pair(first_byte, b) == tail_key);
                return;
            end
            if (p == lim - 1) begin
                w = pair(first_byte, b);
                if (!tail_match) post(ST_BAD_CODE, size_word);
                else if (w != run_sum) post(ST_BAD_SUM, size_word);
                else post(ST_OK, size_word);
            end
        endfunction

        function void match_status(input logic [1:0] st, input logic [WORD_W-1:0] sz);
            t_due_status d;
            if (due_statuses.size() == 0) begin
                errors++;
                $display("%0t: unexpected status %0d size %0d", $time, st, sz);
                return;
            end
            d = due_statuses.pop_front();
            status_hits[d.status]++;
            if (st !== d.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, d.status, st);
            end
            if (sz !== d.size) begin
                errors++;
                $display("%0t: frame_size expected %0d actual %0d", $time, d.size, sz);
            end
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hA5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 i_frame_start;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic [WORD_W-1:0]    o_frame_size;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    frame_status_tracker tracker;
    logic [BYTE_W-1:0]   frame_q[$];
    bit                  pace_in;
    bit                  pace_out;
    bit                  hold_req;
    int unsigned         bytes_sent;
    int unsigned         cycle_count = 0;

    checked_frame_validator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_frame_size  (o_frame_size),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        int unsigned gap;
        gap = pace_in ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_data_byte   = b;
        i_frame_start = start;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_byte(b, start);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg_port(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_regs(input logic [WORD_W-1:0] head, input logic [WORD_W-1:0] tail,
                                input logic [WORD_W-1:0] limit, input logic be);
        write_reg_port(CFG_HEAD_MARKER, head);
        write_reg_port(CFG_TAIL_MARKER, tail);
        write_reg_port(CFG_MAX_PAYLOAD, limit);
        write_reg_port(CFG_BIG_ENDIAN, {15'd0, be});
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (tracker.due_statuses.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic void push_word(input logic [WORD_W-1:0] w);
        if (tracker.msb_first) begin
            frame_q.push_back(w[15:8]);
            frame_q.push_back(w[7:0]);
        end else begin
            frame_q.push_back(w[7:0]);
            frame_q.push_back(w[15:8]);
        end
    endfunction

    function automatic void build_frame(input t_frame_kind kind, input int unsigned plen);
        logic [WORD_W-1:0] hd;
        logic [WORD_W-1:0] sz;
        logic [WORD_W-1:0] tl;
        logic [WORD_W-1:0] cks;
        int unsigned       lo;
        hd = tracker.head_key;
        tl = tracker.tail_key;
        sz = WORD_W'(plen + 8);
        lo = 32'(tracker.payload_limit) + 9;
        case (kind)
            FK_BAD_HEAD:  hd = hd ^ WORD_W'($urandom_range(1, 16'hFFFF));
            FK_BAD_TAIL:  tl = tl ^ WORD_W'($urandom_range(1, 16'hFFFF));
            FK_SIZE_LOW:  sz = WORD_W'($urandom_range(0, 7));
            FK_SIZE_HIGH: sz = WORD_W'((lo <= 16'hFFFF) ? $urandom_range(lo, 16'hFFFF)
                                                        : $urandom_range(0, 7));
            default: ;
        endcase
        frame_q.delete();
        push_word(hd);
        push_word(sz);
        repeat (plen) frame_q.push_back(BYTE_W'($urandom_range(0, 255)));
        push_word(tl);
        cks = '0;
        foreach (frame_q[i]) cks = cks + frame_q[i];
        if (kind == FK_BAD_SUM) cks = cks ^ WORD_W'($urandom_range(1, 16'hFFFF));
        push_word(cks);
    endfunction

    task automatic send_frame(input t_frame_kind kind, input int unsigned plen, input int unsigned cut);
        int unsigned n;
        if (kind == FK_NOISE) begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
            return;
        end
        build_frame(kind, plen);
        n = frame_q.size();
        if (cut != 0 && cut < n) n = cut;
        else if (kind == FK_CUT) n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) send_byte(frame_q[i], i == 0);
    endtask

    function automatic int unsigned random_len();
        int unsigned lim;
        lim = 32'(tracker.payload_limit);
        if ($urandom_range(0, 24) == 0) return $urandom_range(0, lim < 200 ? lim : 200);
        return $urandom_range(0, lim < 12 ? lim : 12);
    endfunction

    function automatic t_frame_kind random_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return FK_GOOD;
        if (r < 60) return FK_CUT;
        if (r < 67) return FK_BAD_HEAD;
        if (r < 72) return FK_SIZE_LOW;
        if (r < 77) return FK_SIZE_HIGH;
        if (r < 85) return FK_BAD_TAIL;
        if (r < 93) return FK_BAD_SUM;
        return FK_NOISE;
    endfunction

    initial begin : result_sink
        int unsigned gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = pace_out ? $urandom_range(0, 19) : 0;
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap != 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.match_status(o_status, o_frame_size);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned target;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_frame_start = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        pace_in       = 1'b1;
        pace_out      = 1'b1;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        tracker       = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: zero markers, 1024 payload limit, msb first
        send_frame(FK_GOOD, 0, 0);
        send_frame(FK_BAD_HEAD, 0, 2);
        send_byte(8'hFF, 1'b0);
        send_frame(FK_SIZE_LOW, 0, 4);
        send_frame(FK_GOOD, 4, 3);
        send_frame(FK_BAD_TAIL, 0, 0);
        drain();
        write_reg_port(CFG_IDX_SPARE, 16'hFFFF);

        phase = 0;
        while (bytes_sent < 900 && phase < 40) begin
            phase++;
            case (phase)
                1: program_regs(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
                2: program_regs(WORD_W'($urandom_range(0, 16'hFFFF)),
                                WORD_W'($urandom_range(0, 16'hFFFF)), 16'd65527, 1'b1);
                3: program_regs(WORD_W'($urandom_range(0, 16'hFFFF)),
                                WORD_W'($urandom_range(0, 16'hFFFF)), 16'd20, 1'b0);
                default: program_regs(WORD_W'($urandom_range(0, 16'hFFFF)),
                                      WORD_W'($urandom_range(0, 16'hFFFF)),
                                      WORD_W'($urandom_range(0, 40)),
                                      1'($urandom_range(0, 1)));
            endcase
            pace_in  = $urandom_range(0, 3) != 0;
            pace_out = $urandom_range(0, 3) != 0;
            if (phase == 3) begin
                pace_in  = 1'b0;
                hold_req = 1'b1;
            end
            if (phase == 2) begin
                // largest legal size, dropped by the next start
                frame_q.delete();
                push_word(tracker.head_key);
                push_word(16'hFFFF);
                repeat (6) frame_q.push_back(BYTE_W'($urandom_range(0, 255)));
                foreach (frame_q[i]) send_byte(frame_q[i], i == 0);
                send_frame(FK_GOOD, 300, 0);
            end
            target = bytes_sent + 120;
            while (bytes_sent < target) send_frame(random_kind(), random_len(), 0);
            send_frame(FK_GOOD, random_len(), 0);
            drain();
        end

        $display("Checked %0d statuses (%0d ok, %0d bad code, %0d bad size, %0d bad sum)",
                 tracker.posted, tracker.status_hits[ST_OK], tracker.status_hits[ST_BAD_CODE],
                 tracker.status_hits[ST_BAD_SIZE], tracker.status_hits[ST_BAD_SUM]);
        $display("from %0d bytes over %0d register settings, with long output hold-off",
                 bytes_sent, phase + 1);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
